### hw/rtl/soa_pkg.sv
package soa_pkg;

	localparam int unsigned NUM_CHANNELS_DEF = 16;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_EFFORT_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DURATION  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOLDOFF = 2'd2;

	localparam logic [14:0] EFFORT_LIMIT_RST  = 15'd32767;
	localparam logic [31:0] MIN_DURATION_RST  = 32'd1000;
	localparam logic [31:0] ALARM_HOLDOFF_RST = 32'd1000;

	typedef struct packed {
		logic [3:0]         channel;
		logic [31:0]        sample_time;
		logic signed [15:0] effort_sample;
	} in_req_t;

	typedef struct packed {
		logic        alarm;
		logic        over_limit;
		logic [31:0] over_duration;
		logic [3:0]  alarm_channel;
	} out_req_t;

	typedef struct packed {
		logic [14:0] effort_limit;
		logic [31:0] min_duration;
		logic [31:0] alarm_holdoff;
	} cfg_t;

	// state update for one channel; both stores take the sample time
	typedef struct packed {
		logic        under_we;
		logic        alarm_we;
		logic [31:0] wr_time;
	} st_wr_t;

endpackage

### hw/rtl/soa_chan_store.sv
module soa_chan_store #(
	parameter int unsigned NUM_CHANNELS = soa_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] rd_addr,
	output logic [31:0]                         under_rd_q,
	output logic [31:0]                         alarm_rd_q,
	input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] wr_addr,
	input  soa_pkg::st_wr_t                     wr
);

	logic [31:0]             under_mem [NUM_CHANNELS];
	logic [31:0]             alarm_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] under_vld_q;
	logic [NUM_CHANNELS-1:0] alarm_vld_q;

	logic hit;
	assign hit = (rd_addr == wr_addr);

	always_ff @(posedge clk) begin
		if (wr.under_we) begin
			under_mem[wr_addr] <= wr.wr_time;
		end
		if (wr.alarm_we) begin
			alarm_mem[wr_addr] <= wr.wr_time;
		end
	end

	// never-written entries read as zero (reset value)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			under_vld_q <= '0;
			alarm_vld_q <= '0;
		end else begin
			if (wr.under_we) begin
				under_vld_q[wr_addr] <= 1'b1;
			end
			if (wr.alarm_we) begin
				alarm_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// registered read, write data forwarded on same-cycle hit
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.under_we && hit) begin
				under_rd_q <= wr.wr_time;
			end else if (under_vld_q[rd_addr]) begin
				under_rd_q <= under_mem[rd_addr];
			end else begin
				under_rd_q <= '0;
			end
			if (wr.alarm_we && hit) begin
				alarm_rd_q <= wr.wr_time;
			end else if (alarm_vld_q[rd_addr]) begin
				alarm_rd_q <= alarm_mem[rd_addr];
			end else begin
				alarm_rd_q <= '0;
			end
		end
	end

endmodule

### hw/rtl/soa_eval.sv
module soa_eval #(
	parameter int unsigned NUM_CHANNELS = soa_pkg::NUM_CHANNELS_DEF
) (
	input  soa_pkg::in_req_t  req,
	input  logic [31:0]       last_under,
	input  logic [31:0]       last_alarm,
	input  soa_pkg::cfg_t     cfg,
	output soa_pkg::out_req_t res,
	output soa_pkg::st_wr_t   wr
);

	logic        in_range;
	logic [15:0] mag;
	logic        over;
	logic [31:0] dur;
	logic [31:0] since_alarm;
	logic        fire;

	always_comb begin
		in_range    = (32'(req.channel) < NUM_CHANNELS);
		// two's complement negate; -32768 yields 32768
		mag         = req.effort_sample[15] ? (16'd0 - req.effort_sample) : req.effort_sample;
		over        = (mag >= {1'b0, cfg.effort_limit});
		dur         = req.sample_time - last_under;
		since_alarm = req.sample_time - last_alarm;
		fire        = in_range && over && (dur >= cfg.min_duration)
			&& (since_alarm >= cfg.alarm_holdoff);

		res.alarm         = fire;
		res.over_limit    = over;
		res.over_duration = (in_range && over) ? dur : 32'd0;
		res.alarm_channel = req.channel;

		wr.under_we = in_range && !over;
		wr.alarm_we = fire;
		wr.wr_time  = req.sample_time;
	end

endmodule

### hw/rtl/sustained_overlimit_alarm_core.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------
// input    | in_valid / in_ready   | in_data  (soa_pkg::in_req_t)
// output   | out_valid / out_ready | out_data (soa_pkg::out_req_t)
// config   | cfg_we                | cfg_index, cfg_data (write only)
//
// One request per cycle sustained unless the output stalls; out_valid rises as
// the request leaves stage 1 for the output register. Stage 1 holds it with
// its channel's state, read from the registered per-channel store; decision
// and write-back happen in that move. Async reset initialises control, config
// and store valid bits at once, no clearing pass. A stalled output holds
// stage 1; in_ready drops only when both stages are full and out_ready is low.
module sustained_overlimit_alarm_core #(
	parameter int unsigned NUM_CHANNELS = soa_pkg::NUM_CHANNELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  soa_pkg::in_req_t                   in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output soa_pkg::out_req_t                  out_data,
	input  logic                               cfg_we,
	input  logic [soa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [soa_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// config registers
	soa_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.effort_limit  <= soa_pkg::EFFORT_LIMIT_RST;
			cfg_q.min_duration  <= soa_pkg::MIN_DURATION_RST;
			cfg_q.alarm_holdoff <= soa_pkg::ALARM_HOLDOFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				soa_pkg::CFG_EFFORT_LIMIT: begin
					cfg_q.effort_limit <= cfg_data[14:0];
				end
				soa_pkg::CFG_MIN_DURATION: begin
					cfg_q.min_duration <= cfg_data;
				end
				soa_pkg::CFG_ALARM_HOLDOFF: begin
					cfg_q.alarm_holdoff <= cfg_data;
				end
				default: begin
					// unmapped index: ignored
				end
			endcase
		end
	end

	// pipeline control
	logic              vld_s1;
	soa_pkg::in_req_t  req_s1;
	logic              out_vld_q;
	soa_pkg::out_req_t res_q;

	logic in_acc;
	logic adv_s1;

	assign adv_s1   = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || adv_s1;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv_s1) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1 <= in_data;
		end
	end

	// per-channel state: read on accept, written as stage 1 retires
	logic [31:0]       under_rd;
	logic [31:0]       alarm_rd;
	soa_pkg::st_wr_t   wr_eval;
	soa_pkg::st_wr_t   wr_mem;
	soa_pkg::out_req_t res_eval;

	always_comb begin
		wr_mem          = wr_eval;
		wr_mem.under_we = wr_eval.under_we && adv_s1;
		wr_mem.alarm_we = wr_eval.alarm_we && adv_s1;
	end

	soa_chan_store #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (in_acc),
		.rd_addr    (AW'(in_data.channel)),
		.under_rd_q (under_rd),
		.alarm_rd_q (alarm_rd),
		.wr_addr    (AW'(req_s1.channel)),
		.wr         (wr_mem)
	);

	soa_eval #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_eval (
		.req        (req_s1),
		.last_under (under_rd),
		.last_alarm (alarm_rd),
		.cfg        (cfg_q),
		.res        (res_eval),
		.wr         (wr_eval)
	);

	// output register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_eval;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = res_q;

endmodule

### verif/sustained_overlimit_alarm_core_tb.sv
module sustained_overlimit_alarm_core_tb;

	localparam int NUM_CH = soa_pkg::NUM_CHANNELS_DEF;

	// ------------------------------------------------------------------
	// Clock, reset and DUT ports. Every input starts at a known value.
	// ------------------------------------------------------------------
	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	soa_pkg::in_req_t               in_data   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	soa_pkg::out_req_t              out_data;
	logic                           cfg_we    = 1'b0;
	logic [soa_pkg::CFG_IDX_W-1:0]  cfg_index = soa_pkg::CFG_EFFORT_LIMIT;
	logic [soa_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	sustained_overlimit_alarm_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Predictor state: our own copy of the registers and of both
	// per-channel timestamp stores, all as they stand after reset.
	// ------------------------------------------------------------------
	logic [14:0] lim_cfg  = soa_pkg::EFFORT_LIMIT_RST;
	logic [31:0] dur_cfg  = soa_pkg::MIN_DURATION_RST;
	logic [31:0] hold_cfg = soa_pkg::ALARM_HOLDOFF_RST;
	logic [31:0] under_ts [NUM_CH] = '{default: '0};
	logic [31:0] alarm_ts [NUM_CH] = '{default: '0};

	soa_pkg::in_req_t  sample_q  [$];  // requests waiting to be driven
	soa_pkg::out_req_t verdict_q [$];  // predicted results, oldest first
	soa_pkg::out_req_t want;

	// stimulus-side view of each channel's clock, keeps time monotonic
	logic [31:0] chan_time [NUM_CH];

	int  src_idle_pct  = 0;
	int  snk_stall_pct = 0;
	bit  src_hold      = 1'b0;
	int  err_cnt       = 0;
	int  n_results     = 0;
	int  n_alarms      = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor. Over-limit test uses the 17-bit magnitude so -32768
	// counts as 32768. Durations and holdoff are mod 2^32 differences,
	// both read before this request updates the stores.
	// ------------------------------------------------------------------
	function automatic soa_pkg::out_req_t judge_sample(soa_pkg::in_req_t s);
		soa_pkg::out_req_t r;
		logic [16:0]       mag;
		logic [31:0]       since_alarm;
		r = '0;
		r.alarm_channel = s.channel;
		mag = s.effort_sample[15] ? 17'h10000 - {1'b0, s.effort_sample}
		                          : {1'b0, s.effort_sample};
		r.over_limit = (mag >= {2'b00, lim_cfg});
		if (int'(s.channel) < NUM_CH) begin
			if (r.over_limit) begin
				since_alarm     = s.sample_time - alarm_ts[s.channel];
				r.over_duration = s.sample_time - under_ts[s.channel];
				if (r.over_duration >= dur_cfg && !(hold_cfg > since_alarm)) begin
					r.alarm = 1'b1;
					alarm_ts[s.channel] = s.sample_time;
				end
			end else begin
				under_ts[s.channel] = s.sample_time;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_v);
		$display("MISMATCH %s on result %0d: got 0x%0h, want 0x%0h",
		         field, n_results, got, exp_v);
		err_cnt++;
	endtask

	// ------------------------------------------------------------------
	// Driver: a request is predicted the edge it is accepted, so the
	// predictor sees requests in exactly the order the DUT does. A new
	// request is only loaded once the slot is free; valid never drops
	// while a request is outstanding.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready)
				verdict_q.push_back(judge_sample(in_data));
			if (!in_valid || in_ready) begin
				if (!src_hold && sample_q.size() != 0 &&
				    $urandom_range(99) >= src_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= sample_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random back-pressure, field-by-field compare against the
	// oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= snk_stall_pct);
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("unexpected result, channel",
					                32'(out_data.alarm_channel), '0);
				end else begin
					want = verdict_q.pop_front();
					if (out_data.alarm !== want.alarm)
						report_mismatch("alarm", 32'(out_data.alarm), 32'(want.alarm));
					if (out_data.over_limit !== want.over_limit)
						report_mismatch("over_limit", 32'(out_data.over_limit),
						                32'(want.over_limit));
					if (out_data.over_duration !== want.over_duration)
						report_mismatch("over_duration", out_data.over_duration,
						                want.over_duration);
					if (out_data.alarm_channel !== want.alarm_channel)
						report_mismatch("alarm_channel", 32'(out_data.alarm_channel),
						                32'(want.alarm_channel));
					if (want.alarm)
						n_alarms++;
				end
				n_results++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Register write; the predictor copy follows at once (only ever
	// called with the pipe empty).
	task automatic write_reg(logic [soa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			soa_pkg::CFG_EFFORT_LIMIT:  lim_cfg  = val[14:0];
			soa_pkg::CFG_MIN_DURATION:  dur_cfg  = val;
			soa_pkg::CFG_ALARM_HOLDOFF: hold_cfg = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every queued request is through and checked, then let the
	// two-stage pipe settle.
	task automatic wait_idle();
		while (sample_q.size() != 0 || in_valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_sample(logic [3:0] ch, logic [31:0] t, logic [15:0] eff);
		soa_pkg::in_req_t s;
		s.channel       = ch;
		s.sample_time   = t;
		s.effort_sample = eff;
		sample_q.push_back(s);
	endtask

	// Effort on the chosen side of the current limit; sign random.
	// A magnitude of 32768 only exists as the most negative code.
	function automatic logic [15:0] pick_effort(bit over);
		logic [16:0] m;
		logic [15:0] v;
		if (over || lim_cfg == 0)
			m = 17'($urandom_range(32768, lim_cfg));
		else
			m = 17'($urandom_range(lim_cfg - 1, 0));
		v = m[15:0];
		if ($urandom_range(1))
			v = -v;
		return v;
	endfunction

	// Mostly well-formed streams: per-channel time moving forward in
	// small steps so that over-limit runs build up duration. The rest
	// is noise: arbitrary times, time running backwards, raw effort.
	task automatic gen_random(int n, int step_max);
		int         roll;
		logic [3:0] ch;
		for (int i = 0; i < n; i++) begin
			ch   = 4'($urandom_range(NUM_CH - 1));
			roll = $urandom_range(99);
			if (roll < 30) begin
				chan_time[ch] += $urandom_range(step_max);
				push_sample(ch, chan_time[ch], pick_effort(1'b0));
			end else if (roll < 88) begin
				chan_time[ch] += $urandom_range(step_max);
				push_sample(ch, chan_time[ch], pick_effort(1'b1));
			end else if (roll < 93) begin
				push_sample(ch, $urandom(), 16'($urandom()));
			end else if (roll < 97) begin
				push_sample(ch, chan_time[ch] - $urandom_range(step_max * 4),
				            pick_effort(1'($urandom_range(1))));
			end else begin
				chan_time[ch] += $urandom_range(step_max);
				push_sample(ch, chan_time[ch], 16'($urandom()));
			end
		end
	endtask

	task automatic run_phase(logic [14:0] lim, logic [31:0] dur, logic [31:0] hold,
	                         int src_pct, int snk_pct, int n, int step_max,
	                         bit mid_pause);
		// upper bits of the limit write are junk the DUT must drop
		write_reg(soa_pkg::CFG_EFFORT_LIMIT, {17'($urandom()), lim});
		write_reg(soa_pkg::CFG_MIN_DURATION, dur);
		write_reg(soa_pkg::CFG_ALARM_HOLDOFF, hold);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		gen_random(n, step_max);
		if (mid_pause) begin
			// hold the sender off mid-stream until the pipe is fully drained
			while (sample_q.size() > n / 2)
				@(posedge clk);
			src_hold = 1'b1;
			while (in_valid || verdict_q.size() != 0)
				@(posedge clk);
			repeat (3) @(posedge clk);
			src_hold = 1'b0;
		end
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, under reset register values (limit 32767, 1000/1000).
		push_sample(4'd0, 32'd5, 16'h0000);           // under limit, duration zero
		push_sample(4'd0, 32'd2000, 16'h7FFF);        // 32767 sits on the limit: alarm
		push_sample(4'd0, 32'd2500, 16'h8000);        // most negative, held off
		push_sample(4'd0, 32'd3000, 16'h8001);        // holdoff just expired
		push_sample(4'd0, 32'd100, 16'h8000);         // time runs backwards: wraps
		push_sample(4'd15, 32'hFFFF_FFFF, 16'h7FFE);  // under, max timestamp
		push_sample(4'd15, 32'h0000_03E6, 16'h8000);  // 999 ticks across the wrap
		push_sample(4'd15, 32'h0000_03E7, 16'h8000);  // exactly min duration
		push_sample(4'd15, 32'h0000_03E8, 16'h7FFF);
		push_sample(4'd15, 32'h0000_0BB8, 16'h7FFF);
		push_sample(4'd7, 32'h0000_0000, 16'h7FFF);   // fresh channel, time zero
		push_sample(4'd7, 32'h8000_0000, 16'hFFFF);   // -1: under
		push_sample(4'd7, 32'hFFFF_FFFF, 16'h0001);
		push_sample(4'd7, 32'hFFFF_FFFF, 16'h8001);   // -32767 at the limit
		push_sample(4'd8, 32'h5555_AAAA, 16'h5555);
		push_sample(4'd8, 32'hAAAA_5555, 16'hAAAA);
		push_sample(4'd8, 32'hFFFF_FFFF, 16'h8000);
		wait_idle();

		for (int c = 0; c < NUM_CH; c++)
			chan_time[c] = $urandom();

		// limit, duration, holdoff, sender idle %, receiver stall %, count, step
		run_phase(15'd12000, 32'd50, 32'd100, 0, 0, 160, 40, 1'b0);
		run_phase(15'd0, 32'd0, 32'd0, 70, 0, 160, 40, 1'b0);
		run_phase(15'd32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 70, 160, 40, 1'b0);
		run_phase(15'($urandom_range(32767)), $urandom_range(300), $urandom_range(300),
		          7, 7, 160, 60, 1'b0);
		run_phase(15'd1, 32'd20, 32'd0, 0, 0, 160, 20, 1'b1);

		repeat (10) @(posedge clk);
		if (verdict_q.size() != 0)
			report_mismatch("results never arrived", verdict_q.size(), 0);

		$display("Checked %0d requests (%0d alarms) over reset defaults and five register sets,",
		         n_results, n_alarms);
		$display("idle mixes none, sender 70%%, receiver 70%%, both 7%%, one full drain pause");
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
